/* design/tjpc_pkg.sv */
// Shared types, codes and helper functions for the junction phase controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tjpc_pkg;

    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    localparam logic [31:0] MAX_GAP = 32'h7fff_ffff;

    // register indexes
    localparam logic [IDX_W-1:0] REG_STARTUP_ALL_RED = 3'd0;
    localparam logic [IDX_W-1:0] REG_VEHICLE_ALL_RED = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAIN_GREEN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAIN_YELLOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIDE_GREEN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIDE_YELLOW     = 3'd5;
    localparam logic [IDX_W-1:0] REG_WALK            = 3'd6;
    localparam logic [IDX_W-1:0] REG_CLEARANCE       = 3'd7;

    typedef logic [NUM_REGS-1:0][31:0] tjpc_cfg_t;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_INIT     = 2'd1,
        CMD_RESTART  = 2'd2,
        CMD_SHUTDOWN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_INVALID  = 2'd2,
        ST_HW_FAIL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_ALL_RED     = 3'd0,
        PH_MAIN_GREEN  = 3'd1,
        PH_MAIN_YELLOW = 3'd2,
        PH_SIDE_GREEN  = 3'd3,
        PH_SIDE_YELLOW = 3'd4,
        PH_WALK        = 3'd5,
        PH_CLEARANCE   = 3'd6,
        PH_FAULT       = 3'd7
    } phase_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now;
        logic        req;
        logic        healthy;
    } tjpc_item_t;

    typedef struct packed {
        phase_t      phase;
        logic        side_next;
        status_t     status;
        logic [31:0] phase_start;
        logic [31:0] last_tick;
        logic        req_latched;
        logic        initialized;
        logic        seen_tick;
        logic        changed;
        logic        accepted;
        logic [31:0] transitions;
    } tjpc_state_t;

    typedef struct packed {
        status_t     result_code;
        status_t     stored_status;
        phase_t      phase;
        logic [7:0]  lamps;
        logic [31:0] phase_start;
        logic [31:0] deadline;
        logic        has_deadline;
        logic        request_pending;
        logic        phase_changed;
        logic        request_accepted;
        logic [31:0] transition_count;
    } tjpc_result_t;

    localparam tjpc_state_t STATE_RESET = '{
        phase:       PH_ALL_RED,
        side_next:   1'b0,
        status:      ST_NOT_INIT,
        phase_start: 32'd0,
        last_tick:   32'd0,
        req_latched: 1'b0,
        initialized: 1'b0,
        seen_tick:   1'b0,
        changed:     1'b0,
        accepted:    1'b0,
        transitions: 32'd0
    };

    // lamp bits: mainred, mainyel, maingrn, sidered, sideyel, sidegrn, pedstop, pedwalk
    function automatic logic [7:0] lamp_pattern(input phase_t ph);
        logic [7:0] lp;
        case (ph)
            PH_ALL_RED:     lp = 8'h49;
            PH_MAIN_GREEN:  lp = 8'h4c;
            PH_MAIN_YELLOW: lp = 8'h4a;
            PH_SIDE_GREEN:  lp = 8'h61;
            PH_SIDE_YELLOW: lp = 8'h51;
            PH_WALK:        lp = 8'h89;
            PH_CLEARANCE:   lp = 8'h49;
            default:        lp = 8'h49;
        endcase
        return lp;
    endfunction

    // startup all-red applies only before the first transition
    function automatic logic [31:0] phase_duration(input phase_t ph,
                                                   input logic [31:0] trans,
                                                   input tjpc_cfg_t cfg);
        logic [31:0] d;
        case (ph)
            PH_ALL_RED:     d = (trans == 32'd0) ? cfg[REG_STARTUP_ALL_RED]
                                                 : cfg[REG_VEHICLE_ALL_RED];
            PH_MAIN_GREEN:  d = cfg[REG_MAIN_GREEN];
            PH_MAIN_YELLOW: d = cfg[REG_MAIN_YELLOW];
            PH_SIDE_GREEN:  d = cfg[REG_SIDE_GREEN];
            PH_SIDE_YELLOW: d = cfg[REG_SIDE_YELLOW];
            PH_WALK:        d = cfg[REG_WALK];
            PH_CLEARANCE:   d = cfg[REG_CLEARANCE];
            default:        d = 32'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/traffic_junction_phase_controller_core.sv */
// Request path: input register, step logic, result register; each request's result is registered.
// Throughput: one request per cycle while out_stall is low; single-pass step logic between the two registers.
// A stalled result holds in the result register while one more request waits in the input register.
// Reset (rst_n, async, active low): durations to defaults, controller not initialized,
// phase all red, counters and flags cleared, both pipeline registers empty.
`timescale 1ns / 1ps

module traffic_junction_phase_controller_core
    import tjpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [31:0]       now_ms,
    input  logic              pedestrian_request,
    input  logic              circuit_healthy,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_code,
    output logic [1:0]        stored_status,
    output logic [2:0]        phase,
    output logic [7:0]        lamps,
    output logic [31:0]       phase_start_ms,
    output logic [31:0]       deadline_ms,
    output logic              has_deadline,
    output logic              request_pending,
    output logic              phase_changed,
    output logic              request_accepted,
    output logic [31:0]       transition_count
);

    tjpc_cfg_t    cfg;
    logic         cfg_ok;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    tjpc_item_t   item_reg;
    tjpc_item_t   item_next;
    tjpc_state_t  state_reg;
    tjpc_state_t  state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    tjpc_result_t res_reg;
    tjpc_result_t res_next;

    tjpc_state_t  st_step;
    tjpc_result_t res_step;

    logic         adv;      // result register can take a new result
    logic         fire;     // step executes this cycle
    logic         in_take;  // request accepted this cycle

    // ---------------------------------------------------------------
    // duration registers
    // ---------------------------------------------------------------
    tjpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_ok  (cfg_ok)
    );

    // ---------------------------------------------------------------
    // handshake: the input register drains whenever the result register
    // is empty or being taken, so requests flow one per cycle
    // ---------------------------------------------------------------
    assign adv      = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_next.cmd     = cmd_t'(command);
        item_next.now     = now_ms;
        item_next.req     = pedestrian_request;
        item_next.healthy = circuit_healthy;

        if (in_take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        // controller state moves only when a step executes; the next
        // request in the input register then sees the updated state
        state_next = fire ? st_step : state_reg;
        res_next   = fire ? res_step : res_reg;
    end

    // ---------------------------------------------------------------
    // step logic
    // ---------------------------------------------------------------
    tjpc_step_logic u_step_logic (
        .st       (state_reg),
        .item     (item_reg),
        .cfg      (cfg),
        .cfg_ok   (cfg_ok),
        .st_step  (st_step),
        .res_step (res_step)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_next;
        end
        res_reg <= res_next;
    end

    // ---------------------------------------------------------------
    // outputs
    // ---------------------------------------------------------------
    assign out_valid        = out_valid_reg;
    assign result_code      = res_reg.result_code;
    assign stored_status    = res_reg.stored_status;
    assign phase            = res_reg.phase;
    assign lamps            = res_reg.lamps;
    assign phase_start_ms   = res_reg.phase_start;
    assign deadline_ms      = res_reg.deadline;
    assign has_deadline     = res_reg.has_deadline;
    assign request_pending  = res_reg.request_pending;
    assign phase_changed    = res_reg.phase_changed;
    assign request_accepted = res_reg.request_accepted;
    assign transition_count = res_reg.transition_count;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // a pending request with room downstream always yields a result next cycle
    a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("pending request did not reach the result register");

    // an uninitialized controller carries no run state
    a_uninit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.initialized |->
            (state_reg.transitions == 32'd0 && !state_reg.seen_tick
             && !state_reg.req_latched))
        else $error("run state present while not initialized");

    // ok status never coexists with the fault phase
    a_ok_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status == ST_OK) |-> (state_reg.phase != PH_FAULT))
        else $error("fault phase with ok status");

endmodule

/* design/tjpc_cfg_regs.sv */
// APB-style register file holding the eight phase durations.
// Depends on tjpc_pkg; also flags whether all durations are valid.
`timescale 1ns / 1ps

module tjpc_cfg_regs
    import tjpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tjpc_cfg_t         cfg,
    output logic              cfg_ok
);

    tjpc_cfg_t        cfg_reg;
    tjpc_cfg_t        cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            cfg_next[idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_STARTUP_ALL_RED] <= 32'd2000;
            cfg_reg[REG_VEHICLE_ALL_RED] <= 32'd1000;
            cfg_reg[REG_MAIN_GREEN]      <= 32'd30000;
            cfg_reg[REG_MAIN_YELLOW]     <= 32'd3000;
            cfg_reg[REG_SIDE_GREEN]      <= 32'd20000;
            cfg_reg[REG_SIDE_YELLOW]     <= 32'd3000;
            cfg_reg[REG_WALK]            <= 32'd10000;
            cfg_reg[REG_CLEARANCE]       <= 32'd5000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = cfg_reg[idx];
    assign cfg    = cfg_reg;

    // valid: nonzero and not above MAX_GAP
    always_comb
    begin
        cfg_ok = 1'b1;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (cfg_reg[IDX_W'(i)] == 32'd0 || cfg_reg[IDX_W'(i)] > MAX_GAP)
            begin
                cfg_ok = 1'b0;
            end
        end
    end

endmodule

/* design/tjpc_step_logic.sv */
// Single-pass step logic: next controller state and result for one request.
// Depends on tjpc_pkg; purely combinational.
`timescale 1ns / 1ps

module tjpc_step_logic
    import tjpc_pkg::*;
(
    input  tjpc_state_t  st,
    input  tjpc_item_t   item,
    input  tjpc_cfg_t    cfg,
    input  logic         cfg_ok,
    output tjpc_state_t  st_step,
    output tjpc_result_t res_step
);

    status_t     rc;
    logic [31:0] start;
    logic [31:0] elapsed;
    logic [31:0] gap;
    logic [31:0] dur_cur;
    logic [31:0] dur_new;
    logic        go;
    phase_t      target;

    assign gap     = item.now - st.last_tick;
    assign start   = st.seen_tick ? st.phase_start : item.now;
    assign elapsed = item.now - start;
    assign dur_cur = phase_duration(st.phase, st.transitions, cfg);

    always_comb
    begin
        st_step = st;
        rc      = ST_OK;
        go      = 1'b0;
        target  = st.phase;
        case (item.cmd)
            CMD_TICK:
            begin
                if (!st.initialized)
                begin
                    rc = ST_NOT_INIT;
                end
                else
                begin
                    st_step.changed  = 1'b0;
                    st_step.accepted = 1'b0;
                    if (st.phase == PH_FAULT)
                    begin
                        rc = st.status;
                    end
                    else if (!item.healthy || (st.seen_tick && gap > MAX_GAP))
                    begin
                        st_step.status      = item.healthy ? ST_INVALID : ST_HW_FAIL;
                        st_step.phase       = PH_FAULT;
                        st_step.phase_start = item.now;
                        st_step.changed     = 1'b1;
                        st_step.transitions = st.transitions + 32'd1;
                        rc                  = item.healthy ? ST_INVALID : ST_HW_FAIL;
                    end
                    else
                    begin
                        st_step.phase_start = start;
                        st_step.seen_tick   = 1'b1;
                        st_step.last_tick   = item.now;
                        if (item.req && !st.req_latched)
                        begin
                            st_step.req_latched = 1'b1;
                            st_step.accepted    = 1'b1;
                        end
                        st_step.status = ST_OK;
                        if (elapsed >= dur_cur)
                        begin
                            go = 1'b1;
                            case (st.phase)
                                PH_ALL_RED:
                                begin
                                    if (st.side_next)
                                        target = PH_SIDE_GREEN;
                                    else if (st_step.req_latched)
                                        target = PH_WALK;
                                    else
                                        target = PH_MAIN_GREEN;
                                end
                                PH_MAIN_GREEN:  target = PH_MAIN_YELLOW;
                                PH_MAIN_YELLOW:
                                begin
                                    st_step.side_next = 1'b1;
                                    target            = PH_ALL_RED;
                                end
                                PH_SIDE_GREEN:  target = PH_SIDE_YELLOW;
                                PH_SIDE_YELLOW:
                                begin
                                    st_step.side_next = 1'b0;
                                    target            = PH_ALL_RED;
                                end
                                PH_WALK:        target = PH_CLEARANCE;
                                PH_CLEARANCE:
                                begin
                                    st_step.side_next = 1'b0;
                                    target            = PH_ALL_RED;
                                end
                                default:        go = 1'b0;
                            endcase
                        end
                        if (go)
                        begin
                            st_step.phase       = target;
                            st_step.phase_start = item.now;
                            st_step.changed     = 1'b1;
                            st_step.transitions = st.transitions + 32'd1;
                            if (target == PH_WALK)
                            begin
                                st_step.req_latched = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_INIT:
            begin
                if (st.initialized)
                begin
                    rc = ST_OK;
                end
                else if (!cfg_ok)
                begin
                    st_step.status = ST_INVALID;
                    st_step.phase  = PH_FAULT;
                    rc             = ST_INVALID;
                end
                else
                begin
                    st_step             = STATE_RESET;
                    st_step.status      = ST_OK;
                    st_step.initialized = 1'b1;
                end
            end
            CMD_RESTART:
            begin
                if (!st.initialized)
                begin
                    rc = ST_NOT_INIT;
                end
                else
                begin
                    st_step             = STATE_RESET;
                    st_step.status      = ST_OK;
                    st_step.initialized = 1'b1;
                end
            end
            default:
            begin
                st_step = STATE_RESET;
            end
        endcase
    end

    assign dur_new = phase_duration(st_step.phase, st_step.transitions, cfg);

    always_comb
    begin
        res_step.result_code      = rc;
        res_step.stored_status    = st_step.status;
        res_step.phase            = st_step.phase;
        res_step.lamps            = lamp_pattern(st_step.phase);
        res_step.phase_start      = st_step.phase_start;
        res_step.deadline         = st_step.phase_start + dur_new;
        res_step.has_deadline     = st_step.initialized && st_step.seen_tick
                                    && (st_step.phase != PH_FAULT);
        res_step.request_pending  = st_step.req_latched;
        res_step.phase_changed    = st_step.changed;
        res_step.request_accepted = st_step.accepted;
        res_step.transition_count = st_step.transitions;
    end

endmodule
